// File: hdl/assert_macros.svh
// Assertion helpers used by the deframer top-level RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk_i outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: hdl/spd_pkg.sv
package spd_pkg;

  // SLIP special bytes
  localparam logic [7:0] CH_END     = 8'hC0;
  localparam logic [7:0] CH_ESC     = 8'hDB;
  localparam logic [7:0] CH_ESC_END = 8'hDC;
  localparam logic [7:0] CH_ESC_ESC = 8'hDD;

  localparam logic [15:0] MAX_LENGTH_RESET = 16'd512;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'b1;

  // Result queue sizing
  localparam int unsigned MAX_RESULTS = 2;
  localparam int unsigned OUT_DEPTH   = 4;
  localparam int unsigned PTR_W       = $clog2(OUT_DEPTH);
  localparam int unsigned CNT_W       = $clog2(OUT_DEPTH + 1);
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_HUNT,
    PH_FRAME
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       length_error;
  } result_t;

endpackage

// File: hdl/stream_packet_deframer_top.sv
// Stream packet deframer.
// Input channel: one received byte per transfer (in_valid_i / in_ready_o).
// Output channel: one payload byte per transfer with last and length_error
// (out_valid_o / out_ready_i). Configuration: cfg_we_i writes cfg_data_i into
// register cfg_index_i (0 frame_mode, 1 max_length); a frame_mode write
// restarts deframing in the new mode.
// Each accepted byte is decoded in the cycle it is taken and yields zero, one
// or two results, which go into a four-entry result queue; from there they are
// offered on the output in order. SLIP payload is held back one byte, so a
// SLIP data byte leaves when the next byte of its frame (or the closing END)
// arrives.
// Throughput: one input byte per cycle while the queue has room for two
// results; the output drains one result per cycle while out_ready_i is high,
// which sets the sustained rate when bytes produce more than one result.
// Reset clears the queue, selects length-prefix mode with max_length 512 and
// waits for a header. When the receiver stalls, results pile up in the queue
// and input is held off once fewer than two free entries remain.
`include "assert_macros.svh"

module stream_packet_deframer_top
  import spd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 last_o,
  output logic                 length_error_o
);

  // Configuration
  logic        frame_mode_q;
  logic [15:0] max_length_q;

  // Deframing state
  phase_e      phase_q, phase_d;
  logic [23:0] header_shift_q, header_shift_d;
  logic [1:0]  header_count_q, header_count_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic [7:0]  held_byte_q, held_byte_d;
  logic        held_valid_q, held_valid_d;
  logic        escape_q, escape_d;

  // Result queue
  result_t          queue_q [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q, count_d;

  result_t              res [MAX_RESULTS];
  logic [RES_CNT_W-1:0] res_cnt;

  logic        in_fire, out_fire, mode_write;
  logic [31:0] header_len;
  logic        len_bad;
  logic [15:0] left_dec;
  logic        esc_pair;

  // Terms used by the checks
  logic        slip_busy, slip_phase, err_dirty;

  assign in_ready_o  = (count_q <= CNT_W'(OUT_DEPTH - MAX_RESULTS));
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign out_fire    = out_valid_o & out_ready_i;
  assign mode_write  = cfg_we_i & (cfg_index_i == CFG_FRAME_MODE);

  assign out_byte_o     = queue_q[rd_ptr_q].data;
  assign last_o         = queue_q[rd_ptr_q].last;
  assign length_error_o = queue_q[rd_ptr_q].length_error;

  // Header value and range check; decrement of the remaining payload count
  assign header_len = {header_shift_q, in_byte_i};
  assign len_bad    = (header_len[31:16] != '0) || (header_len[15:0] == '0) ||
                      (header_len[15:0] > max_length_q);
  assign left_dec   = (bytes_left_q != '0) ? bytes_left_q - 16'd1 : '0;
  assign esc_pair   = escape_q &&
                      ((in_byte_i == CH_ESC_END) || (in_byte_i == CH_ESC_ESC));

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (frame_mode_q) begin
      if (phase_q != PH_FRAME) begin
        phase_d = (in_byte_i == CH_END) ? PH_FRAME : PH_HUNT;
      end else if (!esc_pair && (in_byte_i == CH_END)) begin
        phase_d = PH_HUNT;
      end
    end else begin
      if (phase_q != PH_PAYLOAD) begin
        phase_d = ((header_count_q == 2'd3) && !len_bad) ? PH_PAYLOAD : PH_HEADER;
      end else begin
        phase_d = (left_dec == '0) ? PH_HEADER : PH_PAYLOAD;
      end
    end
  end

  // Datapath and results of one input byte
  always_comb begin
    header_shift_d = header_shift_q;
    header_count_d = header_count_q;
    bytes_left_d   = bytes_left_q;
    held_byte_d    = held_byte_q;
    held_valid_d   = held_valid_q;
    escape_d       = escape_q;
    res[0]         = '0;
    res[1]         = '0;
    res_cnt        = '0;
    if (frame_mode_q) begin
      if (phase_q != PH_FRAME) begin
        // hunt: an END opens a frame
        if (in_byte_i == CH_END) begin
          held_valid_d = 1'b0;
          escape_d     = 1'b0;
        end
      end else if (esc_pair) begin
        // escaped END or ESC: release held byte, hold the decoded one
        escape_d = 1'b0;
        if (held_valid_q) begin
          res[0]  = '{data: held_byte_q, last: 1'b0, length_error: 1'b0};
          res_cnt = RES_CNT_W'(1);
        end
        held_byte_d  = (in_byte_i == CH_ESC_END) ? CH_END : CH_ESC;
        held_valid_d = 1'b1;
      end else begin
        // a lone ESC before another byte counts as data
        if (escape_q) begin
          escape_d = 1'b0;
          if (held_valid_q) begin
            res[0]  = '{data: held_byte_q, last: 1'b0, length_error: 1'b0};
            res_cnt = RES_CNT_W'(1);
          end
          held_byte_d  = CH_ESC;
          held_valid_d = 1'b1;
        end
        if (in_byte_i == CH_END) begin
          // close frame, last goes on the held byte
          if (held_valid_d) begin
            res[res_cnt[0]] = '{data: held_byte_d, last: 1'b1, length_error: 1'b0};
            res_cnt         = res_cnt + RES_CNT_W'(1);
          end
          held_valid_d = 1'b0;
        end else if (in_byte_i == CH_ESC) begin
          escape_d = 1'b1;
        end else begin
          if (held_valid_d) begin
            res[res_cnt[0]] = '{data: held_byte_d, last: 1'b0, length_error: 1'b0};
            res_cnt         = res_cnt + RES_CNT_W'(1);
          end
          held_byte_d  = in_byte_i;
          held_valid_d = 1'b1;
        end
      end
    end else begin
      if (phase_q != PH_PAYLOAD) begin
        // collect header, check it on the fourth byte
        header_shift_d = header_len[23:0];
        header_count_d = header_count_q + 2'd1;
        if (header_count_q == 2'd3) begin
          if (len_bad) begin
            res[0]  = '{data: 8'h00, last: 1'b0, length_error: 1'b1};
            res_cnt = RES_CNT_W'(1);
          end else begin
            bytes_left_d = header_len[15:0];
          end
        end
      end else begin
        bytes_left_d = left_dec;
        res[0]       = '{data: in_byte_i, last: (left_dec == '0), length_error: 1'b0};
        res_cnt      = RES_CNT_W'(1);
      end
    end
  end

  // Queue occupancy
  always_comb begin
    count_d = count_q;
    if (in_fire) begin
      count_d = count_d + CNT_W'(res_cnt);
    end
    if (out_fire) begin
      count_d = count_d - CNT_W'(1);
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_mode_q <= 1'b0;
      max_length_q <= MAX_LENGTH_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_FRAME_MODE) begin
        frame_mode_q <= cfg_data_i[0];
      end else begin
        max_length_q <= cfg_data_i;
      end
    end
  end

  // Control state: restart on a mode write, advance on an input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HEADER;
      header_count_q <= '0;
      held_valid_q   <= 1'b0;
      escape_q       <= 1'b0;
    end else if (mode_write) begin
      phase_q        <= cfg_data_i[0] ? PH_HUNT : PH_HEADER;
      header_count_q <= '0;
      held_valid_q   <= 1'b0;
      escape_q       <= 1'b0;
    end else if (in_fire) begin
      phase_q        <= phase_d;
      header_count_q <= header_count_d;
      held_valid_q   <= held_valid_d;
      escape_q       <= escape_d;
    end
  end

  // Payload state
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      header_shift_q <= header_shift_d;
      bytes_left_q   <= bytes_left_d;
      held_byte_q    <= held_byte_d;
    end
  end

  // Queue pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(res_cnt);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  // Queue storage: write up to two results per transfer
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (res_cnt != '0) begin
        queue_q[wr_ptr_q] <= res[0];
      end
      if (res_cnt == RES_CNT_W'(MAX_RESULTS)) begin
        queue_q[wr_ptr_q + PTR_W'(1)] <= res[1];
      end
    end
  end

  assign slip_busy  = held_valid_q | escape_q;
  assign slip_phase = (phase_q == PH_HUNT) || (phase_q == PH_FRAME);
  assign err_dirty  = length_error_o & (last_o | (out_byte_o != '0));

  `ASSERT_NEVER(a_queue_overflow, count_q > CNT_W'(OUT_DEPTH), "result queue overflow")
  `ASSERT_NEVER(a_error_clean, out_valid_o && err_dirty, "error result carries data")
  `ASSERT_CLK(a_held_in_frame, slip_busy |-> (phase_q == PH_FRAME), "SLIP state out of frame")
  `ASSERT_NEVER(a_mode_phase, !frame_mode_q && slip_phase, "SLIP phase in length mode")

endmodule
